>>> src/djb2_string_bucket_hash_assert.svh
// Assertion macros for the djb2 string bucket hash block.
`ifndef DJB2_STRING_BUCKET_HASH_ASSERT_SVH
`define DJB2_STRING_BUCKET_HASH_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define DJB2_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("djb2 same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled during reset.
`define DJB2_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("djb2 next-cycle check failed");

`endif

>>> src/djb2_pkg.sv
// Package: shared constants, types and command struct for the djb2 hash block.
`timescale 1ns / 1ps

package djb2_pkg;

    localparam int KEY_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int BCOUNT_W    = 16;
    localparam int INDEX_OUT_W = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int KEY_SHIFT   = 5;
    localparam int STEP_W      = $clog2(KEY_W);

    localparam int BUCKET_INDEX_BITS_DEF = 16;
    localparam int NUM_BUCKETS_RESET     = 256;

    localparam logic [KEY_W-1:0] KEY_INIT = 32'd5381;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_BUCKETS = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CASE_FOLD   = 4'd1;

    localparam logic [BYTE_W-1:0] UPPER_A    = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z    = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        logic take;   // input transaction accepted
        logic start;  // accepted transaction closes the name
        logic step;   // one remainder iteration
        logic load;   // move finished result into output registers
    } cmd_t;

endpackage

>>> src/djb2_ctrl.sv
// Controller: sequences key update, remainder iterations and output handoff.
`timescale 1ns / 1ps

module djb2_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    input  logic              last,
    input  logic              hash_stall,
    output logic              char_stall,
    output logic              hash_valid,
    output djb2_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_RUN,
        S_DIV,
        S_DONE
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [djb2_pkg::STEP_W-1:0]     step_reg;
    logic [djb2_pkg::STEP_W-1:0]     step_next;
    logic                            hash_valid_reg;
    logic                            hash_valid_next;
    logic                            out_free;
    logic                            take;

    assign char_stall = (state_reg != S_RUN);
    assign hash_valid = hash_valid_reg;
    assign out_free   = !hash_valid_reg || !hash_stall;
    assign take       = char_valid && (state_reg == S_RUN);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        hash_valid_next = hash_valid_reg;
        cmd             = '0;
        if (hash_valid_reg && !hash_stall)
        begin
            hash_valid_next = 1'b0;
        end
        case (state_reg)
            S_RUN:
            begin
                cmd.take = take;
                if (take && last)
                begin
                    cmd.start  = 1'b1;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == djb2_pkg::STEP_W'(djb2_pkg::KEY_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load        = 1'b1;
                    hash_valid_next = 1'b1;
                    state_next      = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_RUN;
            step_reg       <= '0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

endmodule

>>> src/djb2_dp.sv
// Datapath: config registers, running key, bit-serial remainder and output registers.
`timescale 1ns / 1ps

module djb2_dp
#(
    parameter int BUCKET_INDEX_BITS = djb2_pkg::BUCKET_INDEX_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  djb2_pkg::cmd_t                      cmd,
    input  logic [djb2_pkg::BYTE_W-1:0]         char_byte,
    input  logic                                has_char,
    input  logic                                last,
    input  logic                                cfg_we,
    input  logic [djb2_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [djb2_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [djb2_pkg::INDEX_OUT_W-1:0]    bucket_index,
    output logic [djb2_pkg::KEY_W-1:0]          raw_hash
);

    localparam int CNT_W = (BUCKET_INDEX_BITS < djb2_pkg::BCOUNT_W) ?
                           BUCKET_INDEX_BITS : djb2_pkg::BCOUNT_W;
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(djb2_pkg::NUM_BUCKETS_RESET);

    logic [CNT_W-1:0]                   num_buckets_reg;
    logic                               case_fold_reg;
    djb2_pkg::key_t                     key_reg;
    djb2_pkg::key_t                     final_reg;
    djb2_pkg::key_t                     dividend_reg;
    logic [CNT_W-1:0]                   rem_reg;
    logic [djb2_pkg::INDEX_OUT_W-1:0]   bucket_index_reg;
    djb2_pkg::key_t                     raw_hash_reg;

    djb2_pkg::byte_t                    folded;
    djb2_pkg::key_t                     ext_byte;
    djb2_pkg::key_t                     key_upd;
    logic [CNT_W:0]                     rem_shift;
    logic [CNT_W:0]                     rem_diff;
    logic [CNT_W-1:0]                   rem_next;

    always_comb
    begin
        folded = char_byte;
        if (case_fold_reg && (char_byte >= djb2_pkg::UPPER_A) &&
            (char_byte <= djb2_pkg::UPPER_Z))
        begin
            folded = char_byte + djb2_pkg::CASE_DELTA;
        end
        ext_byte = {{(djb2_pkg::KEY_W - djb2_pkg::BYTE_W){folded[djb2_pkg::BYTE_W-1]}},
                    folded};
        key_upd  = key_reg;
        if (has_char && (char_byte != '0))
        begin
            key_upd = (key_reg << djb2_pkg::KEY_SHIFT) + key_reg + ext_byte;
        end
    end

    // restoring remainder, one dividend bit per step, MSB first
    assign rem_shift = {rem_reg, dividend_reg[djb2_pkg::KEY_W-1]};
    assign rem_diff  = rem_shift - {1'b0, num_buckets_reg};
    assign rem_next  = (rem_shift >= {1'b0, num_buckets_reg}) ?
                       rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_buckets_reg <= CNT_RESET;
            case_fold_reg   <= 1'b0;
            key_reg         <= djb2_pkg::KEY_INIT;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    djb2_pkg::REG_NUM_BUCKETS: num_buckets_reg <= cfg_data[CNT_W-1:0];
                    djb2_pkg::REG_CASE_FOLD:   case_fold_reg   <= cfg_data[0];
                    default:                   ;
                endcase
            end
            if (cmd.take)
            begin
                key_reg <= last ? djb2_pkg::KEY_INIT : key_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            final_reg    <= key_upd;
            dividend_reg <= key_upd;
            rem_reg      <= '0;
        end
        else if (cmd.step)
        begin
            dividend_reg <= dividend_reg << 1;
            rem_reg      <= rem_next;
        end
        if (cmd.load)
        begin
            raw_hash_reg     <= final_reg;
            bucket_index_reg <= (num_buckets_reg == '0) ? '0 :
                                djb2_pkg::INDEX_OUT_W'(rem_reg);
        end
    end

    assign bucket_index = bucket_index_reg;
    assign raw_hash     = raw_hash_reg;

endmodule

>>> src/djb2_string_bucket_hash.sv
// Top level: djb2 string hash with bucket reduction, controller plus datapath.
//
// Input channel (char_valid/char_stall): one byte of a name per transaction,
// with has_char and last. Bytes that do not close a name are accepted back to back.
// A transaction with last set closes the name; the remainder unit then runs
// one dividend bit per cycle, and char_stall stays high until the result
// enters the output register, so no byte of the next name is taken before
// the bit-serial remainder loop has finished.
// Output channel (hash_valid/hash_stall): raw_hash and bucket_index. The
// output register holds a result while hash_stall is high; a stalled result
// only delays the hand-off of the next finished name.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
// the bucket count, index 1 is case_fold; other indexes are ignored. cfg_ready
// is always high; write only while no name is in flight.
// Reset: running key returns to 5381, the bucket count to 256, case_fold to 0,
// no result pending.
`timescale 1ns / 1ps

module djb2_string_bucket_hash
#(
    parameter int BUCKET_INDEX_BITS = djb2_pkg::BUCKET_INDEX_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                char_valid,
    output logic                                char_stall,
    input  logic [djb2_pkg::BYTE_W-1:0]         char_byte,
    input  logic                                has_char,
    input  logic                                last,
    output logic                                hash_valid,
    input  logic                                hash_stall,
    output logic [djb2_pkg::INDEX_OUT_W-1:0]    bucket_index,
    output logic [djb2_pkg::KEY_W-1:0]          raw_hash,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [djb2_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [djb2_pkg::CFG_DATA_W-1:0]     cfg_data
);

    `include "djb2_string_bucket_hash_assert.svh"

    djb2_pkg::cmd_t cmd;
    logic           cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    djb2_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .last       (last),
        .hash_stall (hash_stall),
        .char_stall (char_stall),
        .hash_valid (hash_valid),
        .cmd        (cmd)
    );

    djb2_dp #(
        .BUCKET_INDEX_BITS (BUCKET_INDEX_BITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .char_byte    (char_byte),
        .has_char     (has_char),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .bucket_index (bucket_index),
        .raw_hash     (raw_hash)
    );

    // closing a name blocks the input while the remainder runs
    `DJB2_ASSERT_NXT(a_close_stalls, cmd.start, char_stall)
    // input reopens only when a result is handed to the output register
    `DJB2_ASSERT_IMP(a_reopen_with_result, $fell(char_stall), hash_valid)
    // remainder steps never overlap accepted input
    `DJB2_ASSERT_IMP(a_step_excl_take, cmd.step, !cmd.take && char_stall)

endmodule
